// ===== rtl/core/grdi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package grdi_pkg;

    localparam int HISTORY_DEPTH = 3;
    localparam int CAL_SAMPLES   = 10;

    localparam logic [13:0] ZERO_MAX = 14'd16383;
    localparam logic signed [40:0] ANGLE_MAX = 41'sd549755813887;
    localparam logic signed [40:0] ANGLE_MIN = -41'sd549755813888;

    // largest magnitude the rate and the average can take
    localparam logic [13:0] RATE_MAG_MAX = 14'd5748;

    // reciprocals for division by constants: q0 = (x * RECIP) >> SHIFT,
    // q0 is the true quotient or one less, fixed by one compare
    localparam int SHIFT_57    = 25;
    localparam int SHIFT_SMALL = 20;
    localparam int SHIFT_BIG   = 34;
    localparam logic [24:0] RECIP_57  = 25'((64'd1 << SHIFT_57) / 64'd57);
    localparam logic [24:0] RECIP_6   = 25'((64'd1 << SHIFT_SMALL) / 64'd6);
    localparam logic [24:0] RECIP_CAL = 25'((64'd1 << SHIFT_SMALL) / CAL_SAMPLES);
    // 16 / 15625 scaled by 2^34
    localparam logic [24:0] RECIP_BIG = 25'((64'd1 << (SHIFT_BIG + 4)) / 64'd15625);

    typedef enum logic [1:0] {
        OP_MEASURE = 2'd0,
        OP_CAL     = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RESET   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        DIV_57  = 2'd0,
        DIV_6   = 2'd1,
        DIV_CAL = 2'd2,
        DIV_BIG = 2'd3
    } div_sel_t;

    typedef enum logic [4:0] {
        DP_NONE,
        DP_LOAD,
        DP_DECODE,
        DP_REC,
        DP_QUO,
        DP_BACK,
        DP_FIX,
        DP_RATE,
        DP_SUM,
        DP_PMUL,
        DP_PNUM,
        DP_LO,
        DP_HI,
        DP_QBIG,
        DP_ACC,
        DP_CAL_DONE,
        DP_CLEAR,
        DP_RESET,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    slow;
    } dp_status_t;

    function automatic logic [24:0] div_recip(input div_sel_t sel);
        logic [24:0] m;
        case (sel)
            DIV_57:  m = RECIP_57;
            DIV_6:   m = RECIP_6;
            DIV_CAL: m = RECIP_CAL;
            default: m = RECIP_BIG;
        endcase
        return m;
    endfunction

    function automatic logic [13:0] div_const(input div_sel_t sel);
        logic [13:0] c;
        case (sel)
            DIV_57:  c = 14'd57;
            DIV_6:   c = 14'd6;
            DIV_CAL: c = 14'(CAL_SAMPLES);
            default: c = 14'd15625;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/grdi_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface grdi_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  raw_low;
    logic [7:0]  raw_high;
    logic [19:0] delta_us;

    modport source (output valid, output opcode, output raw_low, output raw_high,
                    output delta_us, input ready);
    modport sink   (input valid, input opcode, input raw_low, input raw_high,
                    input delta_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/grdi_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface grdi_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] rate;
    logic signed [39:0] angle;
    logic [13:0]        zero_level;

    modport source (output valid, output rate, output angle, output zero_level,
                    input ready);
    modport sink   (input valid, input rate, input angle, input zero_level,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/grdi_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grdi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  grdi_pkg::dp_status_t status,
    output grdi_pkg::dp_cmd_t    cmd
);
    import grdi_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DEC,
        ST_R57_REC,
        ST_R57_QUO,
        ST_R57_BACK,
        ST_R57_FIX,
        ST_RATE,
        ST_SUM,
        ST_A6_REC,
        ST_A6_QUO,
        ST_A6_BACK,
        ST_A6_FIX,
        ST_PMUL,
        ST_PNUM,
        ST_BLO,
        ST_BHI,
        ST_BQUO,
        ST_BBACK,
        ST_BFIX,
        ST_ACC,
        ST_C_REC,
        ST_C_QUO,
        ST_C_BACK,
        ST_C_FIX,
        ST_C_DONE,
        ST_CLR,
        ST_RST,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd = '{op: DP_NONE, sel: DIV_57};
        unique case (state_reg)
            ST_IDLE:     cmd.op = in_valid ? DP_LOAD : DP_NONE;
            ST_DISPATCH: cmd.op = DP_NONE;
            ST_DEC:      cmd.op = DP_DECODE;
            ST_R57_REC:  cmd = '{op: DP_REC,  sel: DIV_57};
            ST_R57_QUO:  cmd = '{op: DP_QUO,  sel: DIV_57};
            ST_R57_BACK: cmd = '{op: DP_BACK, sel: DIV_57};
            ST_R57_FIX:  cmd = '{op: DP_FIX,  sel: DIV_57};
            ST_RATE:     cmd.op = DP_RATE;
            ST_SUM:      cmd.op = DP_SUM;
            ST_A6_REC:   cmd = '{op: DP_REC,  sel: DIV_6};
            ST_A6_QUO:   cmd = '{op: DP_QUO,  sel: DIV_6};
            ST_A6_BACK:  cmd = '{op: DP_BACK, sel: DIV_6};
            ST_A6_FIX:   cmd = '{op: DP_FIX,  sel: DIV_6};
            ST_PMUL:     cmd.op = DP_PMUL;
            ST_PNUM:     cmd.op = DP_PNUM;
            ST_BLO:      cmd.op = DP_LO;
            ST_BHI:      cmd.op = DP_HI;
            ST_BQUO:     cmd.op = DP_QBIG;
            ST_BBACK:    cmd = '{op: DP_BACK, sel: DIV_BIG};
            ST_BFIX:     cmd = '{op: DP_FIX,  sel: DIV_BIG};
            ST_ACC:      cmd.op = DP_ACC;
            ST_C_REC:    cmd = '{op: DP_REC,  sel: DIV_CAL};
            ST_C_QUO:    cmd = '{op: DP_QUO,  sel: DIV_CAL};
            ST_C_BACK:   cmd = '{op: DP_BACK, sel: DIV_CAL};
            ST_C_FIX:    cmd = '{op: DP_FIX,  sel: DIV_CAL};
            ST_C_DONE:   cmd.op = DP_CAL_DONE;
            ST_CLR:      cmd.op = DP_CLEAR;
            ST_RST:      cmd.op = DP_RESET;
            ST_FINISH:   cmd.op = out_free ? DP_OUT : DP_NONE;
            default:     cmd.op = DP_NONE;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                unique case (status.opcode)
                    OP_MEASURE: state_next = ST_DEC;
                    OP_CAL:     state_next = ST_C_REC;
                    OP_CLEAR:   state_next = ST_CLR;
                    OP_RESET:   state_next = ST_RST;
                    default:    state_next = ST_RST;
                endcase
            end
            ST_DEC:      state_next = status.slow ? ST_RATE : ST_R57_REC;
            ST_R57_REC:  state_next = ST_R57_QUO;
            ST_R57_QUO:  state_next = ST_R57_BACK;
            ST_R57_BACK: state_next = ST_R57_FIX;
            ST_R57_FIX:  state_next = ST_RATE;
            ST_RATE:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_A6_REC;
            ST_A6_REC:   state_next = ST_A6_QUO;
            ST_A6_QUO:   state_next = ST_A6_BACK;
            ST_A6_BACK:  state_next = ST_A6_FIX;
            ST_A6_FIX:   state_next = ST_PMUL;
            ST_PMUL:     state_next = ST_PNUM;
            ST_PNUM:     state_next = ST_BLO;
            ST_BLO:      state_next = ST_BHI;
            ST_BHI:      state_next = ST_BQUO;
            ST_BQUO:     state_next = ST_BBACK;
            ST_BBACK:    state_next = ST_BFIX;
            ST_BFIX:     state_next = ST_ACC;
            ST_ACC:      state_next = ST_FINISH;
            ST_C_REC:    state_next = ST_C_QUO;
            ST_C_QUO:    state_next = ST_C_BACK;
            ST_C_BACK:   state_next = ST_C_FIX;
            ST_C_FIX:    state_next = ST_C_DONE;
            ST_C_DONE:   state_next = ST_FINISH;
            ST_CLR:      state_next = ST_FINISH;
            ST_RST:      state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result word raised outside finish");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DISPATCH))
        else $error("accepted word not dispatched");

    a_hold_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready) |=>
        (state_reg == ST_FINISH && out_valid_reg))
        else $error("finished word dropped while output stalled");

endmodule

`default_nettype wire

// ===== rtl/core/grdi_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module grdi_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           opcode,
    input  logic [7:0]           raw_low,
    input  logic [7:0]           raw_high,
    input  logic [19:0]          delta_us,
    input  grdi_pkg::dp_cmd_t    cmd,
    output grdi_pkg::dp_status_t status,
    output logic signed [13:0]   rate,
    output logic signed [39:0]   angle,
    output logic [13:0]          zero_level
);
    import grdi_pkg::*;

    // architectural state
    logic [13:0]        zero_reg;
    logic signed [13:0] hist_reg [HISTORY_DEPTH];
    logic signed [39:0] angle_reg;

    // working registers
    opcode_t            op_reg;
    logic               slow_reg;
    logic [13:0]        raw_reg;
    logic [19:0]        dt_reg;
    logic signed [13:0] rate_reg;
    logic               neg_reg;
    logic               sneg_reg;
    logic [36:0]        num_reg;
    logic [22:0]        q_reg;
    logic [49:0]        prod_reg;
    logic [40:0]        lo_reg;

    logic signed [13:0] out_rate_reg;
    logic signed [39:0] out_angle_reg;
    logic [13:0]        out_zero_reg;

    // shared multiplier
    logic [24:0] mul_a, mul_b;
    logic [49:0] mul_p;

    logic [14:0]        diff;
    logic [13:0]        absd;
    logic [17:0]        slow_mag;
    logic [18:0]        absd20;
    logic signed [16:0] sum;
    logic [15:0]        abs_sum;
    logic [57:0]        big_sum;
    logic [37:0]        rem;
    logic [13:0]        dconst;
    logic signed [23:0] inc;
    logic signed [40:0] acc_sum;
    logic signed [39:0] acc_sat;
    logic [14:0]        zsum;

    assign status = '{opcode: op_reg, slow: slow_reg};

    assign rate       = out_rate_reg;
    assign angle      = out_angle_reg;
    assign zero_level = out_zero_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_REC:
            begin
                mul_a = num_reg[24:0];
                mul_b = div_recip(cmd.sel);
            end
            DP_BACK:
            begin
                mul_a = {2'b00, q_reg};
                mul_b = {11'd0, div_const(cmd.sel)};
            end
            DP_PMUL:
            begin
                mul_a = {2'b00, q_reg};
                mul_b = {5'd0, dt_reg};
            end
            DP_LO:
            begin
                mul_a = {9'd0, num_reg[19:4]};
                mul_b = RECIP_BIG;
            end
            DP_HI:
            begin
                mul_a = {8'd0, num_reg[36:20]};
                mul_b = RECIP_BIG;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        diff     = {1'b0, raw_reg} - {1'b0, zero_reg};
        absd     = diff[14] ? 14'(-diff) : diff[13:0];
        slow_mag = ({4'd0, absd} << 3) + ({4'd0, absd} << 1);
        absd20   = ({5'd0, absd} << 4) + ({5'd0, absd} << 2);

        sum = {{3{rate_reg[13]}}, rate_reg}
            + ({{3{hist_reg[0][13]}}, hist_reg[0]} <<< 1)
            + ({{3{hist_reg[1][13]}}, hist_reg[1]} <<< 1)
            + {{3{hist_reg[2][13]}}, hist_reg[2]};
        abs_sum = sum[16] ? 16'(-sum) : sum[15:0];

        big_sum = {prod_reg[41:0], 16'd0} + {17'd0, lo_reg};

        dconst = div_const(cmd.sel);
        rem    = {1'b0, num_reg} - prod_reg[37:0];

        inc     = sneg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
        acc_sum = {angle_reg[39], angle_reg} + {{17{inc[23]}}, inc};
        if (acc_sum > ANGLE_MAX)
            acc_sat = ANGLE_MAX[39:0];
        else if (acc_sum < ANGLE_MIN)
            acc_sat = ANGLE_MIN[39:0];
        else
            acc_sat = acc_sum[39:0];

        zsum = {1'b0, zero_reg} + q_reg[14:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= '0;
            angle_reg <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            unique case (cmd.op)
                DP_ACC:
                begin
                    angle_reg <= acc_sat;
                    for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                        hist_reg[i] <= hist_reg[i - 1];
                    hist_reg[0] <= rate_reg;
                end
                DP_CAL_DONE: zero_reg <= zsum[14] ? ZERO_MAX : zsum[13:0];
                DP_CLEAR:    zero_reg <= '0;
                DP_RESET:
                begin
                    angle_reg <= '0;
                    for (int i = 0; i < HISTORY_DEPTH; i++)
                        hist_reg[i] <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                op_reg   <= opcode_t'(opcode);
                slow_reg <= raw_high[1];
                raw_reg  <= {raw_high[7:2], raw_low};
                num_reg  <= {23'd0, raw_high[7:2], raw_low};
                dt_reg   <= delta_us;
                rate_reg <= '0;
            end
            DP_DECODE:
            begin
                neg_reg <= diff[14];
                q_reg   <= {13'd0, slow_mag[17:8]};
                num_reg <= {18'd0, absd20};
            end
            DP_REC:  prod_reg <= mul_p;
            DP_QUO:
            begin
                if (cmd.sel == DIV_57)
                    q_reg <= 23'(prod_reg >> SHIFT_57);
                else
                    q_reg <= 23'(prod_reg >> SHIFT_SMALL);
            end
            DP_BACK: prod_reg <= mul_p;
            DP_FIX:
            begin
                if (rem >= {24'd0, dconst})
                    q_reg <= q_reg + 23'd1;
            end
            DP_RATE: rate_reg <= neg_reg ? q_reg[13:0] : 14'(-q_reg[13:0]);
            DP_SUM:
            begin
                sneg_reg <= sum[16];
                num_reg  <= {21'd0, abs_sum};
            end
            DP_PMUL: prod_reg <= mul_p;
            DP_PNUM: num_reg  <= {prod_reg[32:0], 4'd0};
            DP_LO:   prod_reg <= mul_p;
            DP_HI:
            begin
                lo_reg   <= prod_reg[40:0];
                prod_reg <= mul_p;
            end
            DP_QBIG: q_reg <= big_sum[56:SHIFT_BIG];
            DP_OUT:
            begin
                out_rate_reg  <= rate_reg;
                out_angle_reg <= angle_reg;
                out_zero_reg  <= zero_reg;
            end
            default: ;
        endcase
    end

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RATE) |=>
        (rate_reg >= -$signed({1'b0, RATE_MAG_MAX}) && rate_reg <= $signed({1'b0, RATE_MAG_MAX})))
        else $error("decoded rate out of range");

    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_PMUL) |-> (q_reg <= {9'd0, RATE_MAG_MAX}))
        else $error("average magnitude out of range");

    a_cal_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_CAL_DONE) |=> (zero_reg >= $past(zero_reg)))
        else $error("calibration decreased zero offset");

endmodule

`default_nettype wire

// ===== rtl/core/gyro_rate_decode_integrate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Measure words in the fast range run the divide-by-57 steps that slow-range
// words skip. One word in flight; the next word is taken in the cycle after
// the result is registered. Every multiplication in the sequence uses the one
// shared 25x25 multiplier. Reset clears zero offset, rate history and angle at
// once; no clearing pass.
module gyro_rate_decode_integrate (
    input  logic      clk,
    input  logic      rst_n,
    grdi_in_if.sink   samples,
    grdi_out_if.source results
);
    import grdi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    grdi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    grdi_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (samples.opcode),
        .raw_low    (samples.raw_low),
        .raw_high   (samples.raw_high),
        .delta_us   (samples.delta_us),
        .cmd        (cmd),
        .status     (status),
        .rate       (results.rate),
        .angle      (results.angle),
        .zero_level (results.zero_level)
    );

endmodule

`default_nettype wire

// ===== verif/tb_gyro_rate_decode_integrate.sv =====
`timescale 1ns / 1ps

module tb_gyro_rate_decode_integrate;

    import grdi_pkg::*;

    localparam int     TOTAL_WORDS = 1150;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint ANGLE_HI = (64'sd1 <<< 39) - 1;
    localparam longint ANGLE_LO = -(64'sd1 <<< 39);

    typedef struct {
        opcode_t     op;
        logic [7:0]  raw_low;
        logic [7:0]  raw_high;
        logic [19:0] delta_us;
    } gyro_word_t;

    typedef struct {
        logic signed [13:0] rate;
        logic signed [39:0] angle;
        logic [13:0]        zero_level;
    } gyro_result_t;

    logic clk = 1'b0;
    logic rst_n;

    grdi_in_if  samples_bus ();
    grdi_out_if results_bus ();

    gyro_rate_decode_integrate uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_bus),
        .results (results_bus)
    );

    // model state
    int     zero_offset_m;
    int     rate_hist_m [3];
    longint angle_m;

    gyro_word_t   pending_words [$];
    gyro_result_t expected_results [$];
    gyro_word_t   word_on_bus;
    int           words_sent;
    int           mismatch_count;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic gyro_word_t make_word(opcode_t op, logic [7:0] lo, logic [7:0] hi,
                                             logic [19:0] dt);
        gyro_word_t w;
        w.op       = op;
        w.raw_low  = lo;
        w.raw_high = hi;
        w.delta_us = dt;
        return w;
    endfunction

    // advances the model by one word and returns the result it should produce
    function automatic gyro_result_t predict_gyro(gyro_word_t w);
        gyro_result_t res;
        longint raw;
        longint diff;
        longint sum;
        longint avg;
        longint acc;
        int     rate;
        int     z;
        raw  = longint'({w.raw_high[7:2], w.raw_low});
        rate = 0;
        case (w.op)
            OP_MEASURE:
            begin
                diff = raw - longint'(zero_offset_m);
                // division on signed operands truncates toward zero
                if (w.raw_high[1])
                    rate = int'(-((diff * 10) / 256));
                else
                    rate = int'(-((diff * 20) / 57));
                sum = longint'(rate) + 2 * longint'(rate_hist_m[0])
                    + 2 * longint'(rate_hist_m[1]) + longint'(rate_hist_m[2]);
                avg = sum / 6;
                acc = angle_m + (avg * longint'(w.delta_us) * 16) / 15625;
                if (acc > ANGLE_HI)
                    acc = ANGLE_HI;
                if (acc < ANGLE_LO)
                    acc = ANGLE_LO;
                angle_m        = acc;
                rate_hist_m[2] = rate_hist_m[1];
                rate_hist_m[1] = rate_hist_m[0];
                rate_hist_m[0] = rate;
            end
            OP_CAL:
            begin
                z = zero_offset_m + int'(raw) / CAL_SAMPLES;
                zero_offset_m = (z > int'(ZERO_MAX)) ? int'(ZERO_MAX) : z;
            end
            OP_CLEAR:
                zero_offset_m = 0;
            default:
            begin
                angle_m     = 0;
                rate_hist_m = '{0, 0, 0};
            end
        endcase
        res.rate       = 14'(rate);
        res.angle      = 40'(angle_m);
        res.zero_level = 14'(zero_offset_m);
        return res;
    endfunction

    // thirds of the run: sender idles lightly, then receiver lightly, then no idling
    function automatic int idle_pct(bit sender_side);
        if (words_sent < TOTAL_WORDS / 3)
            return sender_side ? 21 : 68;
        else if (words_sent < 2 * TOTAL_WORDS / 3)
            return sender_side ? 68 : 21;
        return 0;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < 10)
            $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_bus.valid <= 1'b0;
        end
        else
        begin
            if (samples_bus.valid && samples_bus.ready)
            begin
                expected_results.push_back(predict_gyro(word_on_bus));
                words_sent++;
            end
            if (!samples_bus.valid || samples_bus.ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct(1'b1))
                begin
                    word_on_bus = pending_words.pop_front();
                    samples_bus.valid    <= 1'b1;
                    samples_bus.opcode   <= word_on_bus.op;
                    samples_bus.raw_low  <= word_on_bus.raw_low;
                    samples_bus.raw_high <= word_on_bus.raw_high;
                    samples_bus.delta_us <= word_on_bus.delta_us;
                end
                else
                begin
                    samples_bus.valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_bus.ready <= 1'b0;
        else
            results_bus.ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    // monitor
    always @(posedge clk)
    begin
        gyro_result_t exp_res;
        if (rst_n && results_bus.valid && results_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                flag_mismatch("result word with nothing expected");
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (results_bus.rate !== exp_res.rate
                    || results_bus.angle !== exp_res.angle
                    || results_bus.zero_level !== exp_res.zero_level)
                    flag_mismatch($sformatf(
                        "rate %0d/%0d angle %0d/%0d zero_level %0d/%0d (exp/act)",
                        exp_res.rate, results_bus.rate, exp_res.angle, results_bus.angle,
                        exp_res.zero_level, results_bus.zero_level));
            end
        end
    end

    initial
    begin
        int pick;
        int burst;
        opcode_t op;

        rst_n                = 1'b0;
        samples_bus.valid    = 1'b0;
        samples_bus.opcode   = OP_MEASURE;
        samples_bus.raw_low  = '0;
        samples_bus.raw_high = '0;
        samples_bus.delta_us = '0;
        results_bus.ready    = 1'b0;
        zero_offset_m        = 0;
        rate_hist_m          = '{0, 0, 0};
        angle_m              = 0;
        words_sent           = 0;
        mismatch_count       = 0;

        // directed: field extremes, both ranges, offset saturation, clear and reset
        pending_words.push_back(make_word(OP_RESET, 8'h00, 8'h00, 20'h00000));
        pending_words.push_back(make_word(OP_MEASURE, 8'h00, 8'h00, 20'h00000));
        pending_words.push_back(make_word(OP_MEASURE, 8'hFF, 8'hFF, 20'hFFFFF));
        pending_words.push_back(make_word(OP_MEASURE, 8'hFF, 8'hFD, 20'hFFFFF));
        pending_words.push_back(make_word(OP_MEASURE, 8'h00, 8'h02, 20'hFFFFF));
        pending_words.push_back(make_word(OP_CAL, 8'h09, 8'h00, 20'h00000));
        // eleven full-scale samples push the offset into its ceiling
        repeat (11)
            pending_words.push_back(make_word(OP_CAL, 8'hFF, 8'hFC, 20'($urandom)));
        pending_words.push_back(make_word(OP_MEASURE, 8'h00, 8'h00, 20'hFFFFF));
        pending_words.push_back(make_word(OP_MEASURE, 8'h00, 8'h03, 20'hFFFFF));
        pending_words.push_back(make_word(OP_CLEAR, 8'hAA, 8'h55, 20'hFFFFF));
        pending_words.push_back(make_word(OP_MEASURE, 8'h55, 8'hA8, 20'd12345));
        pending_words.push_back(make_word(OP_RESET, 8'hFF, 8'hFF, 20'hFFFFF));
        pending_words.push_back(make_word(OP_MEASURE, 8'h00, 8'h80, 20'd10000));

        while (pending_words.size() < TOTAL_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // calibration run as at start-up
                burst = $urandom_range(14, 8);
                repeat (burst)
                    pending_words.push_back(make_word(OP_CAL, 8'($urandom),
                                                      8'($urandom), 20'($urandom)));
            end
            else
            begin
                if (pick < 78)
                    op = OP_MEASURE;
                else if (pick < 88)
                    op = OP_CAL;
                else if (pick < 94)
                    op = OP_CLEAR;
                else
                    op = OP_RESET;
                case ($urandom_range(3))
                    0: pending_words.push_back(make_word(op, 8'($urandom), 8'($urandom),
                                                         20'($urandom)));
                    1: pending_words.push_back(make_word(op, 8'($urandom), 8'($urandom),
                                                         20'($urandom_range(12000, 8000))));
                    2: pending_words.push_back(make_word(op, 8'($urandom), 8'($urandom),
                                                         20'($urandom_range(300))));
                    default: pending_words.push_back(make_word(op, 8'($urandom),
                                                     8'($urandom),
                                                     $urandom_range(1) ? 20'hFFFFF
                                                                       : 20'h00000));
                endcase
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || samples_bus.valid
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("gyro_rate_decode_integrate regression: pass");
        else
            $display("gyro_rate_decode_integrate regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("gyro_rate_decode_integrate regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/grdi_pkg.sv
rtl/core/grdi_in_if.sv
rtl/core/grdi_out_if.sv
rtl/core/grdi_ctrl.sv
rtl/core/grdi_datapath.sv
rtl/core/gyro_rate_decode_integrate.sv
verif/tb_gyro_rate_decode_integrate.sv
